### rtl/sla_pkg.sv
// ----------------------------------------------------------------------------
// Serial line assembler package
// Shared request codes, result kinds, line constants and the queue types.
// ----------------------------------------------------------------------------
package sla_pkg;

  // request codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_FAULT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_TAKE  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // line buffer holds LINE_CAPACITY-1 characters
  localparam int LINE_CAPACITY = 64;
  localparam int LINE_MAX      = LINE_CAPACITY - 1;
  localparam int LW            = $clog2(LINE_MAX);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [6:0]  character;
    logic [LW-1:0] position;
    logic        last;
    logic        error_was_set;
  } res_t;

endpackage

### rtl/sla_front.sv
// ----------------------------------------------------------------------------
// Serial line assembler front end
// Accepts requests into a short queue and hands them to the back end in order.
// ----------------------------------------------------------------------------
module sla_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_rx_byte,
  output logic              busy,
  output logic              head_valid,
  output sla_pkg::cmd_t     head,
  input  logic              pop
);

  sla_pkg::cmd_t             q_r [sla_pkg::QDEPTH];
  logic [sla_pkg::QPW-1:0]   wp_r, wp_nxt;
  logic [sla_pkg::QPW-1:0]   rp_r, rp_nxt;
  logic [sla_pkg::QPW:0]     cnt_r, cnt_nxt;
  logic                      push;
  sla_pkg::cmd_t             cmd_in;

  assign busy       = (cnt_r == (sla_pkg::QPW+1)'(sla_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];
  assign push       = start && !busy;

  // only the byte request carries data; clear it otherwise
  always_comb begin
    cmd_in.op   = in_command;
    cmd_in.data = (in_command == sla_pkg::CMD_BYTE) ? in_rx_byte : 8'd0;
  end

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

### rtl/sla_engine.sv
// ----------------------------------------------------------------------------
// Serial line assembler back end
// Runs requests: ring writes, line scan one byte a cycle, character emission.
// ----------------------------------------------------------------------------
module sla_engine #(
  parameter int RING_DEPTH = 128,
  parameter int SCAN_LIMIT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  sla_pkg::cmd_t     head,
  output logic              pop,
  output sla_pkg::res_t     res
);

  localparam int RW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(SCAN_LIMIT + 1);
  localparam int LW = sla_pkg::LW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [7:0]    ring_mem [RING_DEPTH];
  logic [6:0]    line_mem [sla_pkg::LINE_MAX];
  logic [7:0]    ring_rdata_r;
  logic [6:0]    line_rdata_r;

  logic [1:0]    state_r, state_nxt;
  logic [RW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [RW-1:0] wr_inc, rd_inc;
  logic          err_r, err_nxt;
  logic          drop_r, drop_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] eidx_r, eidx_nxt;
  logic [LW-1:0] elen_r, elen_nxt;
  logic          ring_we, line_we;
  logic          is_eol, is_bad, emit_last;
  sla_pkg::res_t res_r, res_nxt;

  assign res    = res_r;
  assign wr_inc = (wr_r == RW'(RING_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == RW'(RING_DEPTH - 1)) ? '0 : rd_r + 1'b1;

  assign is_eol = (ring_rdata_r == sla_pkg::CHAR_CR) || (ring_rdata_r == sla_pkg::CHAR_LF);
  assign is_bad = (ring_rdata_r < sla_pkg::PRINT_LO) || (ring_rdata_r > sla_pkg::PRINT_HI) ||
                  (len_r >= LW'(sla_pkg::LINE_MAX));
  assign emit_last = (eidx_r == elen_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    err_nxt   = err_r;
    drop_nxt  = drop_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    eidx_nxt  = eidx_r;
    elen_nxt  = elen_r;
    pop       = 1'b0;
    ring_we   = 1'b0;
    line_we   = 1'b0;
    res_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.op)
            sla_pkg::CMD_BYTE: begin
              // ring keeps one slot free; a full ring loses the byte
              if (wr_inc == rd_r) begin
                err_nxt = 1'b1;
              end else begin
                ring_we = 1'b1;
                wr_nxt  = wr_inc;
              end
            end
            sla_pkg::CMD_FAULT: begin
              err_nxt = 1'b1;
            end
            sla_pkg::CMD_READ: begin
              state_nxt = ST_SCAN;
              cnt_nxt   = '0;
            end
            default: begin
              res_nxt.valid         = 1'b1;
              res_nxt.kind          = sla_pkg::KIND_ERR;
              res_nxt.last          = 1'b1;
              res_nxt.error_was_set = err_r;
              err_nxt               = 1'b0;
              if (err_r) begin
                rd_nxt   = wr_r;
                len_nxt  = '0;
                drop_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(SCAN_LIMIT) || rd_r == wr_r) begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = sla_pkg::KIND_NONE;
          res_nxt.last  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_nxt  = rd_inc;
          cnt_nxt = cnt_r + 1'b1;
          if (is_eol) begin
            if (drop_r) begin
              drop_nxt = 1'b0;
              len_nxt  = '0;
            end else if (len_r != '0) begin
              state_nxt = ST_EMIT;
              elen_nxt  = len_r;
              eidx_nxt  = '0;
              len_nxt   = '0;
            end
          end else if (is_bad) begin
            drop_nxt = 1'b1;
            err_nxt  = 1'b1;
          end else if (!drop_r) begin
            line_we = 1'b1;
            len_nxt = len_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        res_nxt.valid     = 1'b1;
        res_nxt.kind      = sla_pkg::KIND_CHAR;
        res_nxt.character = line_rdata_r;
        res_nxt.position  = eidx_r;
        res_nxt.last      = emit_last;
        if (emit_last) begin
          eidx_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          eidx_nxt = eidx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wr_r    <= '0;
      rd_r    <= '0;
      err_r   <= 1'b0;
      drop_r  <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
      eidx_r  <= '0;
      elen_r  <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      err_r   <= err_nxt;
      drop_r  <= drop_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      eidx_r  <= eidx_nxt;
      elen_r  <= elen_nxt;
      res_r   <= res_nxt;
    end
  end

  // read at the next index so the data lines up with the index register
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_r] <= head.data;
    end
    ring_rdata_r <= ring_mem[rd_nxt];
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[len_r] <= ring_rdata_r[6:0];
    end
    line_rdata_r <= line_mem[eidx_nxt];
  end

endmodule

### rtl/serial_line_assembler_fifo.sv
// ----------------------------------------------------------------------------
// Serial line assembler with receive ring
// Queues requests, stores received bytes and assembles printable lines.
// ----------------------------------------------------------------------------
// Timing: an accepted request is popped while the back end is idle; a take
//   error strobes its result in the cycle after the pop, and a read strobes its
//   first result after the scan of its ring bytes.
// Flow: byte, fault and take-error leave the back end idle; a read scans one
//   ring byte per cycle (up to SCAN_LIMIT), then emits one character per cycle
//   or the no-line result, and the back end pops no request until it is done.
// The four-entry request queue raises busy when full; results cannot stall.
// Reset: synchronous; clears indices, flags, queue and outputs, not the stores.
module serial_line_assembler_fifo #(
  parameter int RING_DEPTH = 128,
  parameter int SCAN_LIMIT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [6:0] out_character,
  output logic [5:0] out_position,
  output logic       out_last,
  output logic       out_error_was_set
);

  logic          head_valid;
  logic          pop;
  sla_pkg::cmd_t head;
  sla_pkg::res_t res;

  sla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sla_engine #(
    .RING_DEPTH (RING_DEPTH),
    .SCAN_LIMIT (SCAN_LIMIT)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );

  assign out_valid         = res.valid;
  assign out_kind          = res.kind;
  assign out_character     = res.character;
  assign out_position      = res.position;
  assign out_last          = res.last;
  assign out_error_was_set = res.error_was_set;

`ifndef ASSERT_OFF
  a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sla_pkg::KIND_CHAR |-> out_last)
    else $error("non-character result without last mark");

  a_char_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sla_pkg::KIND_CHAR && !out_last |=>
      out_valid && out_kind == sla_pkg::KIND_CHAR &&
      out_position == $past(out_position) + 6'd1)
    else $error("line characters not contiguous");

  a_zero_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sla_pkg::KIND_CHAR |-> out_character == 7'd0 &&
      out_position == 6'd0)
    else $error("character fields set outside a line result");

  a_reset_quiet : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule
